FILE: sv/itp_pkg.sv
package itp_pkg;

    // Operator stack geometry.
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // Input token kinds.
    localparam logic [3:0] F_NUMBER = 4'd0;
    localparam logic [3:0] F_PLUS   = 4'd1;
    localparam logic [3:0] F_MINUS  = 4'd2;
    localparam logic [3:0] F_TIMES  = 4'd3;
    localparam logic [3:0] F_DIVIDE = 4'd4;
    localparam logic [3:0] F_POWER  = 4'd5;
    localparam logic [3:0] F_LPAREN = 4'd6;
    localparam logic [3:0] F_RPAREN = 4'd7;
    localparam logic [3:0] F_END    = 4'd8;

    // Result kinds and stack entry codes.
    localparam logic [2:0] K_NUMBER = 3'd0;
    localparam logic [2:0] K_PLUS   = 3'd1;
    localparam logic [2:0] K_MINUS  = 3'd2;
    localparam logic [2:0] K_TIMES  = 3'd3;
    localparam logic [2:0] K_DIVIDE = 3'd4;
    localparam logic [2:0] K_POWER  = 3'd5;
    localparam logic [2:0] K_LPAREN = 3'd6;
    localparam logic [2:0] K_MARK   = 3'd6;

    // Error codes.
    localparam logic [2:0] E_OK          = 3'd0;
    localparam logic [2:0] E_INVALID     = 3'd1;
    localparam logic [2:0] E_UNMATCHED_R = 3'd2;
    localparam logic [2:0] E_OVERFLOW    = 3'd3;
    localparam logic [2:0] E_UNMATCHED_L = 3'd4;

    // Stack operations.
    typedef logic [2:0] t_sop;
    localparam t_sop SOP_NONE    = 3'd0;
    localparam t_sop SOP_PUSH    = 3'd1;
    localparam t_sop SOP_POP     = 3'd2;
    localparam t_sop SOP_REPLACE = 3'd3;
    localparam t_sop SOP_CLEAR   = 3'd4;

    // Sources of a result.
    typedef logic [1:0] t_src;
    localparam t_src SRC_NUMBER = 2'd0;
    localparam t_src SRC_TOP    = 2'd1;
    localparam t_src SRC_MARK   = 2'd2;

    typedef struct packed {
        logic       load;
        logic       emit;
        t_src       src;
        logic [2:0] err;
        logic       last;
        t_sop       sop;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] func;
        logic       cnt_zero;
        logic       cnt_full;
        logic       top_lp;
        logic       top_pops;
        logic       next_live;
        logic       next_lp;
        logic       next_pops;
        logic       out_free;
    } t_dp_sts;

    function automatic logic [1:0] f_prec(input logic [2:0] k);
        logic [1:0] p;
        case (k)
            K_PLUS, K_MINUS:  p = 2'd0;
            K_TIMES, K_DIVIDE: p = 2'd1;
            default:          p = 2'd2;
        endcase
        return p;
    endfunction

    // True when stacked entry t must be popped before operator k is pushed.
    function automatic logic f_pops(input logic [2:0] t, input logic [2:0] k);
        logic [1:0] pt;
        logic [1:0] pk;
        pt = f_prec(t);
        pk = f_prec(k);
        return (t != K_LPAREN) && ((pt > pk) || ((pt == pk) && (t != K_POWER)));
    endfunction

endpackage

FILE: sv/itp_dp.sv
module itp_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itp_pkg::t_dp_cmd  i_cmd,
    output itp_pkg::t_dp_sts  o_sts,
    input  logic [3:0]        i_func,
    input  logic [63:0]       i_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_kind,
    output logic [63:0]       o_value,
    output logic              o_last,
    output logic [2:0]        o_err
);
    import itp_pkg::*;

    logic [2:0]       r_stack [STACK_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [2:0]       r_top;
    logic [2:0]       r_next;
    logic [3:0]       r_func;
    logic [63:0]      r_value;
    logic             r_valid;
    logic [2:0]       r_kind;
    logic [63:0]      r_out_value;
    logic             r_last;
    logic [2:0]       r_err;

    logic [CNT_W-1:0] w_cnt_m1;
    logic [CNT_W-1:0] w_cnt_m3;
    logic [2:0]       w_push;

    assign w_cnt_m1 = r_count - CNT_W'(1);
    assign w_cnt_m3 = r_count - CNT_W'(3);
    // Operators and '(' are stored under their own three-bit codes.
    assign w_push   = r_func[2:0];

    always_comb begin
        n_count = r_count;
        case (i_cmd.sop)
            SOP_PUSH:  n_count = r_count + CNT_W'(1);
            SOP_POP:   n_count = w_cnt_m1;
            SOP_CLEAR: n_count = '0;
            default:   n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Stack memory; the top two entries are also held in registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.sop)
            SOP_PUSH: begin
                r_stack[r_count[IDX_W-1:0]] <= w_push;
                r_next <= r_top;
                r_top  <= w_push;
            end
            SOP_REPLACE: begin
                r_stack[w_cnt_m1[IDX_W-1:0]] <= w_push;
                r_top <= w_push;
            end
            SOP_POP: begin
                r_top  <= r_next;
                r_next <= r_stack[w_cnt_m3[IDX_W-1:0]];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_last <= i_cmd.last;
            case (i_cmd.src)
                SRC_NUMBER: begin
                    r_kind      <= K_NUMBER;
                    r_out_value <= r_value;
                    r_err       <= E_OK;
                end
                SRC_TOP: begin
                    r_kind      <= r_top;
                    r_out_value <= '0;
                    r_err       <= E_OK;
                end
                default: begin
                    r_kind      <= K_MARK;
                    r_out_value <= '0;
                    r_err       <= i_cmd.err;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.func      = r_func;
        o_sts.cnt_zero  = (r_count == '0);
        o_sts.cnt_full  = (r_count == CNT_W'(STACK_DEPTH));
        o_sts.top_lp    = (r_top == K_LPAREN);
        o_sts.top_pops  = f_pops(r_top, r_func[2:0]);
        o_sts.next_live = (r_count > CNT_W'(1));
        o_sts.next_lp   = (r_next == K_LPAREN);
        o_sts.next_pops = f_pops(r_next, r_func[2:0]);
        o_sts.out_free  = !r_valid || i_ready;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_out_value;
    assign o_last  = r_last;
    assign o_err   = r_err;

endmodule

FILE: sv/itp_ctrl.sv
module itp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  itp_pkg::t_dp_sts  i_sts,
    output itp_pkg::t_dp_cmd  o_cmd
);
    import itp_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state;
    logic n_state;
    logic w_done;

    always_comb begin
        o_cmd      = '0;
        o_cmd.src  = SRC_MARK;
        o_cmd.err  = E_OK;
        o_cmd.sop  = SOP_NONE;
        w_done     = 1'b0;
        o_in_ready = (r_state == S_IDLE);
        n_state    = r_state;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.out_free) begin
                    case (i_sts.func)
                        F_NUMBER: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.src  = SRC_NUMBER;
                            o_cmd.last = 1'b1;
                            w_done     = 1'b1;
                        end
                        F_PLUS, F_MINUS, F_TIMES, F_DIVIDE, F_POWER: begin
                            if (!i_sts.cnt_zero && i_sts.top_pops) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.src  = SRC_TOP;
                                // When the entry below stops the popping, the push
                                // overwrites the popped slot in the same cycle.
                                if (i_sts.next_live && i_sts.next_pops) begin
                                    o_cmd.sop = SOP_POP;
                                end else begin
                                    o_cmd.last = 1'b1;
                                    o_cmd.sop  = SOP_REPLACE;
                                    w_done     = 1'b1;
                                end
                            end else if (i_sts.cnt_full) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.err  = E_OVERFLOW;
                                o_cmd.last = 1'b1;
                                o_cmd.sop  = SOP_CLEAR;
                                w_done     = 1'b1;
                            end else begin
                                o_cmd.sop = SOP_PUSH;
                                w_done    = 1'b1;
                            end
                        end
                        F_LPAREN: begin
                            if (i_sts.cnt_full) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.err  = E_OVERFLOW;
                                o_cmd.last = 1'b1;
                                o_cmd.sop  = SOP_CLEAR;
                            end else begin
                                o_cmd.sop = SOP_PUSH;
                            end
                            w_done = 1'b1;
                        end
                        F_RPAREN: begin
                            if (i_sts.cnt_zero) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.err  = E_UNMATCHED_R;
                                o_cmd.last = 1'b1;
                                w_done     = 1'b1;
                            end else if (i_sts.top_lp) begin
                                // Matching '(' is dropped without a result.
                                o_cmd.sop = SOP_POP;
                                w_done    = 1'b1;
                            end else begin
                                o_cmd.emit = 1'b1;
                                o_cmd.src  = SRC_TOP;
                                o_cmd.last = i_sts.next_live && i_sts.next_lp;
                                o_cmd.sop  = SOP_POP;
                            end
                        end
                        F_END: begin
                            o_cmd.emit = 1'b1;
                            if (i_sts.cnt_zero) begin
                                o_cmd.last = 1'b1;
                                w_done     = 1'b1;
                            end else if (i_sts.top_lp) begin
                                o_cmd.err  = E_UNMATCHED_L;
                                o_cmd.last = 1'b1;
                                o_cmd.sop  = SOP_CLEAR;
                                w_done     = 1'b1;
                            end else begin
                                o_cmd.src = SRC_TOP;
                                o_cmd.sop = SOP_POP;
                            end
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.err  = E_INVALID;
                            o_cmd.last = 1'b1;
                            o_cmd.sop  = SOP_CLEAR;
                            w_done     = 1'b1;
                        end
                    endcase
                    if (w_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/infix_to_postfix_converter.sv
// A token is loaded while idle; each of its results is registered in the output register.
// A number, an operator, '(' or an invalid token is done in the working step of its last pop, or
// in its only step; ')' and end need a step of their own after the last pop for the dropped '(',
// the end marker or the error result. No new token is taken before the previous one is done.
// Every working step also waits until the output register is free or drains in that step.
// Reset (i_rst_n low, synchronous) empties the operator stack and drops any pending result.
module infix_to_postfix_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Token input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] token_value
    input  logic [3:0]  s_axis_tuser,   // [3:0] func
    // Postfix output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] out_value
    output logic        m_axis_tlast,   // last result caused by one token
    output logic [5:0]  m_axis_tuser    // [2:0] out_kind, [5:3] error_code
);
    import itp_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_sts    w_sts;
    logic [2:0] w_kind;
    logic [2:0] w_err;

    // The controller takes one token at a time and steps through its pops,
    // one per cycle, whenever the output register is free or being drained
    // in the same cycle. The output register lets the next token be taken
    // while the last result of the previous one still waits for a transfer.
    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the token, the operator stack with its top two
    // entries cached in registers, and the output register. Every result
    // knows whether it is the last one for its token, since the entry below
    // the top is always at hand.
    itp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_func  (s_axis_tuser),
        .i_value (s_axis_tdata),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (w_kind),
        .o_value (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_err   (w_err)
    );

    assign m_axis_tuser = {w_err, w_kind};

endmodule
